// ===== rtl/atoi_any_base_parser_unit_assert.svh =====
// Assertion macros for the any-radix integer parser.
// Included by atoi_any_base_parser_unit, which checks its own logic; depends on nothing else.
`ifndef ATOI_ANY_BASE_PARSER_UNIT_ASSERT_SVH
`define ATOI_ANY_BASE_PARSER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define ATOI_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("atoi parser check failed");

// Condition that must never be seen outside reset.
`define ATOI_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("atoi parser forbidden condition seen");

`else

`define ATOI_ASSERT(lbl, clk, rst_n, prop)
`define ATOI_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== rtl/atoi_pkg.sv =====
// Shared types and constants for the any-radix integer parser.
// No dependencies; every other file but the assertion header refers to it by scoped names.
package atoi_pkg;

    // Field widths of the character channel.
    localparam int CMD_W       = 2;
    localparam int CHAR_W      = 8;
    localparam int ALPHA_DEPTH = 1 << CHAR_W;

    // Default width of the parsed value.
    localparam int VALUE_BITS_DEF = 32;

    // Command codes carried with every item.
    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_TEXT   = 2'd2,
        CMD_UNUSED = 2'd3
    } cmd_t;

    // Character codes that the alphabet check and the text scanner use.
    localparam logic [CHAR_W-1:0] CH_NUL      = 8'd0;
    localparam logic [CHAR_W-1:0] CH_TAB      = 8'd9;
    localparam logic [CHAR_W-1:0] CH_CR       = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE    = 8'd32;
    localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'd33;
    localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'd126;
    localparam logic [CHAR_W-1:0] CH_PLUS     = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS    = 8'h2D;

    // Radix limits.
    localparam logic [CHAR_W-1:0] RADIX_MAX = 8'd255;
    localparam logic [CHAR_W-1:0] RADIX_MIN = 8'd2;

    // Text item after the alphabet lookup, handed from the lookup stage to the parser.
    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] char_code;
        logic              last;
        logic              present;
        logic [CHAR_W-1:0] digit;
        logic [CHAR_W-1:0] radix;
        logic              base_valid;
    } text_item_t;

endpackage

// ===== rtl/atoi_in_if.sv =====
// Character channel of the any-radix integer parser: valid/ready plus item fields.
// Depends on atoi_pkg for the field widths.
interface atoi_in_if;

    logic                          valid;
    logic                          ready;
    logic [atoi_pkg::CMD_W-1:0]    cmd;
    logic [atoi_pkg::CHAR_W-1:0]   char_code;
    logic                          last;

    modport source (output valid, output cmd, output char_code, output last, input ready);
    modport sink   (input valid, input cmd, input char_code, input last, output ready);

endinterface

// ===== rtl/atoi_out_if.sv =====
// Result channel of the any-radix integer parser: valid/ready plus result fields.
// Depends on atoi_pkg for the default value width.
interface atoi_out_if #(
    parameter int VALUE_BITS = atoi_pkg::VALUE_BITS_DEF
);

    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;
    logic                         out_of_range;
    logic                         base_valid;

    modport source (output valid, output value, output out_of_range, output base_valid,
                    input ready);
    modport sink   (input valid, input value, input out_of_range, input base_valid,
                    output ready);

endinterface

// ===== rtl/atoi_alpha.sv =====
// Alphabet store and lookup stage: presence bits, digit memory, radix and validity.
// Text items leave through a registered stage with their lookup results; uses atoi_pkg.
module atoi_alpha (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        acc,
    input  logic [atoi_pkg::CMD_W-1:0]  cmd,
    input  logic [atoi_pkg::CHAR_W-1:0] char_code,
    input  logic                        last,
    input  logic                        adv,
    output atoi_pkg::text_item_t        item
);

    logic [atoi_pkg::ALPHA_DEPTH-1:0] present_reg;
    logic [atoi_pkg::ALPHA_DEPTH-1:0] present_next;
    logic [atoi_pkg::CHAR_W-1:0]      radix_reg;
    logic [atoi_pkg::CHAR_W-1:0]      radix_next;
    logic                             bad_reg;
    logic                             bad_next;
    logic [atoi_pkg::CHAR_W-1:0]      digit_mem [atoi_pkg::ALPHA_DEPTH];

    logic                             s1_valid_reg;
    logic                             s1_valid_next;
    logic [atoi_pkg::CHAR_W-1:0]      s1_char_reg;
    logic                             s1_last_reg;
    logic                             s1_present_reg;
    logic [atoi_pkg::CHAR_W-1:0]      s1_digit_reg;
    logic [atoi_pkg::CHAR_W-1:0]      s1_radix_reg;
    logic                             s1_base_valid_reg;

    logic                             is_clear;
    logic                             is_append;
    logic                             is_text;
    logic                             char_present;
    logic                             printable;
    logic                             mem_wr;

    // Decode the accepted item.
    assign is_clear     = acc && (cmd == atoi_pkg::CMD_CLEAR);
    assign is_append    = acc && (cmd == atoi_pkg::CMD_APPEND);
    assign is_text      = acc && (cmd == atoi_pkg::CMD_TEXT);
    assign char_present = present_reg[char_code];
    assign printable    = (char_code >= atoi_pkg::CH_PRINT_LO)
                       && (char_code <= atoi_pkg::CH_PRINT_HI)
                       && (char_code != atoi_pkg::CH_PLUS)
                       && (char_code != atoi_pkg::CH_MINUS);

    // A first occurrence of a nonzero character gets the current radix as its digit.
    assign mem_wr = is_append && (char_code != atoi_pkg::CH_NUL) && !char_present;

    // Alphabet state update.
    always_comb
    begin
        present_next = present_reg;
        radix_next   = radix_reg;
        bad_next     = bad_reg;
        if (is_clear)
        begin
            present_next = '0;
            radix_next   = '0;
            bad_next     = 1'b0;
        end
        else if (is_append)
        begin
            if (char_code == atoi_pkg::CH_NUL)
            begin
                bad_next = 1'b1;
            end
            else
            begin
                if (!printable || char_present)
                begin
                    bad_next = 1'b1;
                end
                if (!char_present)
                begin
                    present_next[char_code] = 1'b1;
                end
                if (radix_reg != atoi_pkg::RADIX_MAX)
                begin
                    radix_next = radix_reg + 1'b1;
                end
            end
        end
    end

    // The lookup stage fills with each text item and empties when the parser takes it.
    assign s1_valid_next = is_text ? 1'b1 : (s1_valid_reg && !adv);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg  <= '0;
            radix_reg    <= '0;
            bad_reg      <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            present_reg  <= present_next;
            radix_reg    <= radix_next;
            bad_reg      <= bad_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Digit memory with registered read, plus the payload of the lookup stage.
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            digit_mem[char_code] <= radix_reg;
        end
        if (is_text)
        begin
            s1_digit_reg      <= digit_mem[char_code];
            s1_char_reg       <= char_code;
            s1_last_reg       <= last;
            s1_present_reg    <= char_present;
            s1_radix_reg      <= radix_reg;
            s1_base_valid_reg <= !bad_reg && (radix_reg >= atoi_pkg::RADIX_MIN);
        end
    end

    assign item.valid      = s1_valid_reg;
    assign item.char_code  = s1_char_reg;
    assign item.last       = s1_last_reg;
    assign item.present    = s1_present_reg;
    assign item.digit      = s1_digit_reg;
    assign item.radix      = s1_radix_reg;
    assign item.base_valid = s1_base_valid_reg;

endmodule

// ===== rtl/atoi_parse.sv =====
// Text scanner and accumulator with the result register of the parser.
// Takes looked-up text items from atoi_alpha; uses atoi_pkg and atoi_out_if.
module atoi_parse #(
    parameter int VALUE_BITS = atoi_pkg::VALUE_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  atoi_pkg::text_item_t item,
    output logic                 adv,
    atoi_out_if.source           results
);

    localparam int SUM_W = VALUE_BITS + atoi_pkg::CHAR_W + 1;
    localparam int MUL_W = VALUE_BITS + atoi_pkg::CHAR_W;
    localparam logic [SUM_W-1:0] LIM_W = SUM_W'(1) << (VALUE_BITS - 1);

    // Scan phase of the current string.
    typedef enum logic [2:0] {
        PH_LEADING = 3'b001,
        PH_DIGITS  = 3'b010,
        PH_DONE    = 3'b100
    } phase_t;

    phase_t                  phase_reg;
    phase_t                  phase_next;
    logic                    neg_reg;
    logic                    neg_next;
    logic [VALUE_BITS-1:0]   mag_reg;
    logic [VALUE_BITS-1:0]   mag_next;
    logic                    ovf_reg;
    logic                    ovf_next;

    logic                    out_valid_reg;
    logic [VALUE_BITS-1:0]   out_value_reg;
    logic                    out_oor_reg;
    logic                    out_base_reg;

    logic                    skip_char;
    logic                    is_digit;
    logic [MUL_W-1:0]        mul;
    logic [SUM_W-1:0]        sum;
    logic                    emit;
    logic                    res_oor;
    logic [VALUE_BITS-1:0]   res_value;

    // The item moves on unless it ends a string and the result register is still full.
    assign adv  = item.valid && !(item.last && out_valid_reg && !results.ready);
    assign emit = adv && item.last;

    // Character classes.
    always_comb
    begin
        skip_char = item.char_code inside {[atoi_pkg::CH_TAB:atoi_pkg::CH_CR],
                                           atoi_pkg::CH_SPACE, atoi_pkg::CH_PLUS,
                                           atoi_pkg::CH_MINUS};
    end
    assign is_digit = item.present && (item.char_code != atoi_pkg::CH_NUL);

    // One accumulation step: magnitude times radix plus digit.
    assign mul = MUL_W'(mag_reg) * MUL_W'(item.radix);
    assign sum = SUM_W'(mul) + SUM_W'(item.digit);

    // Scan state update for the current character.
    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        ovf_next   = ovf_reg;
        if ((phase_reg == PH_LEADING) && skip_char)
        begin
            if (item.char_code == atoi_pkg::CH_MINUS)
            begin
                neg_next = !neg_reg;
            end
        end
        else if (phase_reg != PH_DONE)
        begin
            if (is_digit)
            begin
                phase_next = PH_DIGITS;
                if (!ovf_reg)
                begin
                    if (sum > LIM_W)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        mag_next = sum[VALUE_BITS-1:0];
                    end
                end
            end
            else
            begin
                phase_next = PH_DONE;
            end
        end
    end

    // The magnitude never exceeds the limit, so its top bit marks exactly the limit.
    assign res_oor   = ovf_next || (!neg_next && mag_next[VALUE_BITS-1]);
    assign res_value = res_oor ? '0 : (neg_next ? (~mag_next) + VALUE_BITS'(1) : mag_next);

    // Scan state and result handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LEADING;
            neg_reg       <= 1'b0;
            mag_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                if (item.last)
                begin
                    phase_reg <= PH_LEADING;
                    neg_reg   <= 1'b0;
                    mag_reg   <= '0;
                    ovf_reg   <= 1'b0;
                end
                else
                begin
                    phase_reg <= phase_next;
                    neg_reg   <= neg_next;
                    mag_reg   <= mag_next;
                    ovf_reg   <= ovf_next;
                end
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_value_reg <= res_value;
            out_oor_reg   <= res_oor;
            out_base_reg  <= item.base_valid;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.value        = out_value_reg;
    assign results.out_of_range = out_oor_reg;
    assign results.base_valid   = out_base_reg;

endmodule

// ===== rtl/atoi_any_base_parser_unit.sv =====
// Any-radix signed integer parser, one character per item. Alphabet items (clear,
// append) update a 256-entry presence bit vector, cleared at once by a clear item, and a
// 256 x 8 digit memory; the radix counts the nonzero characters appended, up to 255.
// Text items pass a lookup register, where the digit memory is read, and then the
// accumulator, where one multiply by the radix and one add update the magnitude, into a
// result register. One item is accepted every cycle, except when a last character meets
// a result register still holding an untaken result; a string's result enters the result
// register as its last character leaves the lookup register. No clearing pass runs after
// reset. Depends on atoi_pkg, atoi_in_if, atoi_out_if, atoi_alpha, atoi_parse.
`include "atoi_any_base_parser_unit_assert.svh"

module atoi_any_base_parser_unit #(
    parameter int VALUE_BITS = atoi_pkg::VALUE_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    atoi_in_if.sink    chars,
    atoi_out_if.source results
);

    atoi_pkg::text_item_t s1;
    logic                 adv;
    logic                 acc;

    // The lookup register is free when empty or when its item moves on this cycle.
    assign chars.ready = !s1.valid || adv;
    assign acc         = chars.valid && chars.ready;

    // Alphabet store and lookup stage.
    atoi_alpha u_alpha (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc       (acc),
        .cmd       (chars.cmd),
        .char_code (chars.char_code),
        .last      (chars.last),
        .adv       (adv),
        .item      (s1)
    );

    // Scanner, accumulator and result register.
    atoi_parse #(
        .VALUE_BITS (VALUE_BITS)
    ) u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (s1),
        .adv     (adv),
        .results (results)
    );

    // A stalled text item stays in the lookup register.
    `ATOI_ASSERT(a_s1_hold, clk, rst_n, s1.valid && !adv |=> s1.valid)
    // An accepted text item is in the lookup register on the next cycle.
    `ATOI_ASSERT(a_text_loaded, clk, rst_n, acc && (chars.cmd == atoi_pkg::CMD_TEXT) |=> s1.valid)
    // A new result follows only a last character that moved into the accumulator.
    `ATOI_ASSERT(a_result_source, clk, rst_n, $rose(results.valid) |-> $past(adv && s1.last))
    // An out-of-range result always carries the value zero.
    `ATOI_ASSERT_NEVER(a_oor_zero, clk, rst_n, results.valid && results.out_of_range && (results.value != '0))

endmodule
